/* sv/assert_macros.svh */
// Assertion macros included by the stack top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on rising clk, suspended while arst_n is low.
`define AST_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising clk, reset included.
`define AST_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_RST(lbl, prop, msg)
`define AST_ANY(lbl, prop, msg)
`endif
`endif

/* sv/nms_pkg.sv */
// Types and constants of the medium identifier stack.
package nms_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int ID_BITS     = 16;

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	// widened views used before masking into the fixed result fields
	localparam int FPW   = (IDX_W > 4) ? IDX_W : 4;
	localparam int DCW   = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [1:0] {
		KIND_ENTER  = 2'd0,
		KIND_EXIT   = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] entry_id;
		logic [3:0]  position;
	} req_word_t;

	typedef struct packed {
		logic       found;
		logic [3:0] found_position;
		logic [4:0] depth_now;
		logic [1:0] status;
	} rsp_word_t;

	// per-cell control from the stack controller
	typedef struct packed {
		logic live;   // cell holds a valid entry
		logic load;   // take the pushed identifier
		logic shift;  // take the entry of the cell above
	} cell_ctl_t;
endpackage

/* sv/nms_if.sv */
// Valid/ready channels carrying request and response words.
interface nms_req_if;
	logic                  valid;
	logic                  ready;
	nms_pkg::req_word_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nms_rsp_if;
	logic                  valid;
	logic                  ready;
	nms_pkg::rsp_word_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/nested_medium_stack.sv */
// Top level of the medium identifier stack.
//
//  channel | dir | word        | fields
//  --------+-----+-------------+------------------------------------------
//  req     | in  | req_word_t  | kind, entry_id, position
//  rsp     | out | rsp_word_t  | found, found_position, depth_now, status
//
// Every request word is handled in the cycle it is accepted; its response
// word is registered and shows in the next cycle. One word per cycle while
// rsp is taken; the single response register sets that rate.
// Reset empties the stack (count to zero) and drops a pending response.
// A stalled response holds req.ready low until rsp.ready returns.
module nested_medium_stack (
	input  logic          clk,
	input  logic          arst_n,
	nms_req_if.sink       req,
	nms_rsp_if.source     rsp
);
	import nms_pkg::*;

	// stack count and response register
	logic [CNT_W-1:0] cnt_q;
	logic             rv_q;
	rsp_word_t        rsp_q;

	logic accept;
	logic full;
	logic empty;
	logic is_enter;
	logic is_exit;
	logic is_clear;

	// the row of cells, each one below the top wired to its upper neighbor
	cell_ctl_t          ctl    [STACK_DEPTH];
	logic [ID_BITS-1:0] ent    [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] hit;

	logic [ID_BITS-1:0] req_id;
	logic [FPW-1:0]     pos_ext;

	logic             any_hit;
	logic [IDX_W-1:0] hit_idx;
	logic [FPW-1:0]   hit_idx_ext;

	logic [CNT_W-1:0] cnt_next;
	logic [DCW-1:0]   cnt_next_ext;
	rsp_word_t        rsp_d;

	// a new request goes in when the response slot is free or draining
	assign req.ready = !rv_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_enter  = (req.data.kind == KIND_ENTER);
	assign is_exit   = (req.data.kind == KIND_EXIT);
	assign is_clear  = (req.data.kind == KIND_CLEAR);

	assign full  = (cnt_q == CNT_W'(STACK_DEPTH));
	assign empty = (cnt_q == '0);

	// identifier narrowed (or widened) to the stored width
	assign req_id  = ID_BITS'(req.data.entry_id);
	assign pos_ext = FPW'(req.data.position);

	genvar g;
	generate
		for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
			logic [ID_BITS-1:0] above;

			if (g == STACK_DEPTH - 1) begin : g_top
				// top cell never shifts; nothing above it
				assign above = '0;
			end else begin : g_mid
				assign above = ent[g+1];
			end

			// live: below the count; load: push lands here;
			// shift: at or above the exit position and below the new top
			assign ctl[g].live  = (CNT_W'(g) < cnt_q);
			assign ctl[g].load  = accept && is_enter && (cnt_q == CNT_W'(g));
			assign ctl[g].shift = accept && is_exit &&
				(FPW'(g) >= pos_ext) && (CNT_W'(g + 1) < cnt_q);

			nms_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[g]),
				.push_id   (req_id),
				.above_id  (above),
				.search_id (req_id),
				.entry     (ent[g]),
				.hit       (hit[g])
			);
		end
	endgenerate

	nms_prio u_prio (
		.hit (hit),
		.any (any_hit),
		.idx (hit_idx)
	);

	assign hit_idx_ext = FPW'(hit_idx);

	// next count and the response word
	always_comb begin
		cnt_next = cnt_q;
		rsp_d    = '0;
		case (kind_t'(req.data.kind))
			KIND_ENTER: begin
				if (full) begin
					rsp_d.status = ST_OVERFLOW;
				end else begin
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			KIND_EXIT: begin
				if (empty) begin
					rsp_d.status = ST_UNDERFLOW;
				end else begin
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			KIND_LOOKUP: begin
				rsp_d.found          = any_hit;
				rsp_d.found_position = any_hit ? hit_idx_ext[3:0] : 4'd0;
			end
			KIND_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				cnt_next = cnt_q;
			end
		endcase
		cnt_next_ext    = DCW'(cnt_next);
		rsp_d.depth_now = cnt_next_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_next;
				rv_q  <= 1'b1;
			end else if (rsp.ready) begin
				rv_q  <= 1'b0;
			end
		end
	end

	// response payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rv_q;
	assign rsp.data  = rsp_q;

`include "assert_macros.svh"

	`AST_RST(a_cnt_bound, (cnt_q <= CNT_W'(STACK_DEPTH)), "stack count beyond depth")
	`AST_RST(a_found_ok, (rsp.valid && rsp.data.found) |-> (rsp.data.status == ST_OK), "found with bad status")
	`AST_RST(a_overflow, (accept && is_enter && full) |=> (rsp.data.status == ST_OVERFLOW), "missed overflow")
	`AST_RST(a_clear, (accept && is_clear) |=> (cnt_q == '0), "clear left entries")
endmodule

/* sv/nms_cell.sv */
// One stack cell: holds an entry, loads, shifts down, compares.
module nms_cell (
	input  logic                         clk,
	input  nms_pkg::cell_ctl_t           ctl,
	input  logic [nms_pkg::ID_BITS-1:0]  push_id,
	input  logic [nms_pkg::ID_BITS-1:0]  above_id,
	input  logic [nms_pkg::ID_BITS-1:0]  search_id,
	output logic [nms_pkg::ID_BITS-1:0]  entry,
	output logic                         hit
);
	import nms_pkg::*;

	logic [ID_BITS-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= push_id;
		end else if (ctl.shift) begin
			entry_q <= above_id;
		end
	end

	assign entry = entry_q;
	assign hit   = ctl.live && (entry_q == search_id);
endmodule

/* sv/nms_prio.sv */
// Lowest-index priority encoder over the cell match lines.
module nms_prio (
	input  logic [nms_pkg::STACK_DEPTH-1:0] hit,
	output logic                            any,
	output logic [nms_pkg::IDX_W-1:0]       idx
);
	import nms_pkg::*;

	always_comb begin
		idx = '0;
		for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign any = |hit;
endmodule
